// ===== sv/fla_pkg.sv =====
// Shared types and constants of the free-list heap allocator.
`timescale 1ns / 1ps
`default_nettype none
package fla_pkg;

  // Width of a request size in header units: ceil(8191 / 8) + 1 needs 11 bits.
  localparam int UNITS_W = 11;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_A_START,
    ST_A_NEXT,
    ST_A_CHK,
    ST_A_SPLIT,
    ST_F_START,
    ST_F_CHK,
    ST_F_RD,
    ST_F_LNK,
    ST_F_RDP,
    ST_F_LOW,
    ST_RESP
  } fla_state_t;

endpackage
`default_nettype wire

// ===== sv/fla_hdr_ram.sv =====
// One-write, one-read header memory with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module fla_hdr_ram #(
  parameter int DEPTH = 1025,
  parameter int AW    = 11,
  parameter int DW    = 11
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== sv/free_list_heap_allocator.sv =====
// Top level of the free-list heap allocator: sequencer, walk datapath and header memories.
// Sequence: an allocate goes through setup and a start read, then checks each free-list
// node examined, with one more split step for a split; growing the break adds an
// address-ordered insert walk before the allocate walk starts again.
// A free runs setup, checks each node up to its insert point, then reads, links, reads the
// predecessor and merges low; a free of payload unit zero or beyond the heap answers from setup.
// Throughput: one request at a time; the next is taken after the result is delivered.
// The walk speed is set by the single read port of each header memory.
// Reset (synchronous, rst_n low) empties the list state; no memory clearing pass is run.
`timescale 1ns / 1ps
`default_nettype none
module free_list_heap_allocator
  import fla_pkg::*;
#(
  parameter int HEAP_UNITS = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_req_type,
  input  wire logic [12:0] in_request_bytes,
  input  wire logic [9:0]  in_payload_unit,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic      [9:0]  out_granted_unit,
  output logic             out_failed
);

  // Index width covers the heap units plus the sentinel entry at HEAP_UNITS.
  localparam int IW   = $clog2(HEAP_UNITS + 1);
  localparam int SW   = (IW > UNITS_W) ? IW : UNITS_W;
  localparam int CW   = SW + 1;
  localparam int KW   = IW + 1;
  localparam int XW   = (IW >= 10) ? IW + 1 : 11;
  localparam int CNTW = $clog2(4 * HEAP_UNITS + 9) + 1;
  localparam logic [IW-1:0]   SENT = IW'(HEAP_UNITS);
  localparam logic [CNTW-1:0] ALLOC_LIMIT = CNTW'(4 * HEAP_UNITS + 8);
  localparam logic [CNTW-1:0] FREE_LIMIT  = CNTW'(2 * HEAP_UNITS + 4);

  // Sentinel orders below every heap unit.
  function automatic logic [KW-1:0] order_key(input logic [IW-1:0] idx);
    order_key = (idx == SENT) ? '0 : (KW'(idx) + KW'(1));
  endfunction

  fla_state_t state_r, state_nxt;

  logic [IW-1:0]      rover_r, rover_nxt;
  logic [IW-1:0]      brk_r, brk_nxt;
  logic               started_r, started_nxt;
  logic               is_alloc_r, is_alloc_nxt;
  logic               skip_r, skip_nxt;
  logic [UNITS_W-1:0] units_r, units_nxt;
  logic [IW-1:0]      bp_r, bp_nxt;
  logic [IW-1:0]      prev_r, prev_nxt;
  logic [IW-1:0]      cur_r, cur_nxt;
  logic [IW-1:0]      q_r, q_nxt;
  logic [IW-1:0]      nq_r, nq_nxt;
  logic [IW-1:0]      nb_r, nb_nxt;
  logic [IW-1:0]      upper_r, upper_nxt;
  logic [SW-1:0]      sb_r, sb_nxt;
  logic [CNTW-1:0]    astep_r, astep_nxt;
  logic [CNTW-1:0]    fstep_r, fstep_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [9:0]         out_unit_r, out_unit_nxt;
  logic               out_fail_r, out_fail_nxt;

  // Header memory ports: one for next links, one for sizes.
  logic          nx_we, sz_we;
  logic [IW-1:0] nx_waddr, nx_raddr, nx_wdata, nx_rdata;
  logic [IW-1:0] sz_waddr, sz_raddr;
  logic [SW-1:0] sz_wdata, sz_rdata;

  fla_hdr_ram #(.DEPTH(HEAP_UNITS + 1), .AW(IW), .DW(IW)) u_next_ram (
    .clk   (clk),
    .we    (nx_we),
    .waddr (nx_waddr),
    .wdata (nx_wdata),
    .raddr (nx_raddr),
    .rdata (nx_rdata)
  );

  fla_hdr_ram #(.DEPTH(HEAP_UNITS + 1), .AW(IW), .DW(SW)) u_size_ram (
    .clk   (clk),
    .we    (sz_we),
    .waddr (sz_waddr),
    .wdata (sz_wdata),
    .raddr (sz_raddr),
    .rdata (sz_rdata)
  );

  // Decisions shared by the next-state and datapath logic.
  logic [XW-1:0] unit_m1;
  logic          free_ok;
  logic          fit_ge, fit_eq, at_rover, upper_bad, grow_bad;
  logic          astep_over, fstep_over, ins_found, hi_adj, lo_adj;
  logic [CW-1:0] upper_w, grow_w;
  logic [KW-1:0] kb, kp, kq;

  assign unit_m1    = XW'(in_payload_unit) - XW'(1);
  assign free_ok    = (in_payload_unit != '0) && (unit_m1 < XW'(HEAP_UNITS));
  assign fit_ge     = CW'(sz_rdata) >= CW'(units_r);
  assign fit_eq     = CW'(sz_rdata) == CW'(units_r);
  assign at_rover   = cur_r == rover_r;
  assign upper_w    = CW'(cur_r) + CW'(sz_rdata) - CW'(units_r);
  assign upper_bad  = upper_w >= CW'(HEAP_UNITS);
  assign grow_w     = CW'(brk_r) + CW'(units_r);
  assign grow_bad   = grow_w >= CW'(HEAP_UNITS);
  assign astep_over = astep_r >= ALLOC_LIMIT;
  assign fstep_over = fstep_r > FREE_LIMIT;
  assign kb         = order_key(bp_r);
  assign kp         = order_key(cur_r);
  assign kq         = order_key(nx_rdata);
  // The insert point lies between p and its successor, or at the list wrap.
  assign ins_found  = ((kb > kp) && (kb < kq)) || ((kp >= kq) && ((kb > kp) || (kb < kq)));
  assign hi_adj     = (q_r != SENT) && ((CW'(bp_r) + CW'(sb_r)) == CW'(q_r));
  assign lo_adj     = (cur_r != SENT) && ((CW'(cur_r) + CW'(sz_rdata)) == CW'(bp_r));

  function automatic logic [9:0] grant_of(input logic [IW-1:0] hdr);
    logic [XW-1:0] g;
    g = XW'(hdr) + XW'(1);
    grant_of = g[9:0];
  endfunction

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_INIT;
        end
      end
      ST_INIT: begin
        if (is_alloc_r) begin
          state_nxt = ST_A_START;
        end else if (skip_r) begin
          state_nxt = ST_RESP;
        end else begin
          state_nxt = ST_F_START;
        end
      end
      ST_A_START: state_nxt = ST_A_NEXT;
      ST_A_NEXT:  state_nxt = ST_A_CHK;
      ST_A_CHK: begin
        if (astep_over) begin
          state_nxt = ST_RESP;
        end else if (fit_ge) begin
          state_nxt = (fit_eq || upper_bad) ? ST_RESP : ST_A_SPLIT;
        end else if (at_rover) begin
          state_nxt = grow_bad ? ST_RESP : ST_F_START;
        end
      end
      ST_A_SPLIT: state_nxt = ST_RESP;
      ST_F_START: state_nxt = ST_F_CHK;
      ST_F_CHK: begin
        if (fstep_over) begin
          state_nxt = is_alloc_r ? ST_A_START : ST_RESP;
        end else if (ins_found) begin
          state_nxt = ST_F_RD;
        end
      end
      ST_F_RD:  state_nxt = ST_F_LNK;
      ST_F_LNK: state_nxt = ST_F_RDP;
      ST_F_RDP: state_nxt = ST_F_LOW;
      ST_F_LOW: state_nxt = is_alloc_r ? ST_A_START : ST_RESP;
      ST_RESP: begin
        if (!out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath, memory control and result logic.
  always_comb begin
    rover_nxt     = rover_r;
    brk_nxt       = brk_r;
    started_nxt   = started_r;
    is_alloc_nxt  = is_alloc_r;
    skip_nxt      = skip_r;
    units_nxt     = units_r;
    bp_nxt        = bp_r;
    prev_nxt      = prev_r;
    cur_nxt       = cur_r;
    q_nxt         = q_r;
    nq_nxt        = nq_r;
    nb_nxt        = nb_r;
    upper_nxt     = upper_r;
    sb_nxt        = sb_r;
    astep_nxt     = astep_r;
    fstep_nxt     = fstep_r;
    out_valid_nxt = out_valid_r;
    out_unit_nxt  = out_unit_r;
    out_fail_nxt  = out_fail_r;
    nx_we         = 1'b0;
    nx_waddr      = cur_r;
    nx_wdata      = bp_r;
    nx_raddr      = cur_r;
    sz_we         = 1'b0;
    sz_waddr      = cur_r;
    sz_wdata      = sb_r;
    sz_raddr      = cur_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          is_alloc_nxt = in_req_type == REQ_ALLOC;
          skip_nxt     = !free_ok;
          units_nxt    = UNITS_W'((UNITS_W'(in_request_bytes >> 3))
                         + UNITS_W'(in_request_bytes[2:0] != 3'd0) + UNITS_W'(1));
          bp_nxt       = IW'(unit_m1);
          astep_nxt    = '0;
        end
      end
      ST_INIT: begin
        // The first request of either kind builds the empty circular list.
        if (!started_r) begin
          nx_we       = 1'b1;
          nx_waddr    = SENT;
          nx_wdata    = SENT;
          sz_we       = 1'b1;
          sz_waddr    = SENT;
          sz_wdata    = '0;
          rover_nxt   = SENT;
          started_nxt = 1'b1;
        end
        if (!is_alloc_r && skip_r) begin
          out_valid_nxt = 1'b1;
          out_unit_nxt  = '0;
          out_fail_nxt  = 1'b0;
        end
      end
      ST_A_START: begin
        prev_nxt = rover_r;
        nx_raddr = rover_r;
      end
      ST_A_NEXT: begin
        cur_nxt  = nx_rdata;
        nx_raddr = nx_rdata;
        sz_raddr = nx_rdata;
      end
      ST_A_CHK: begin
        if (astep_over) begin
          out_valid_nxt = 1'b1;
          out_unit_nxt  = '0;
          out_fail_nxt  = 1'b1;
        end else if (fit_ge) begin
          if (fit_eq) begin
            // Exact fit: unlink the block from its predecessor.
            nx_we         = 1'b1;
            nx_waddr      = prev_r;
            nx_wdata      = nx_rdata;
            rover_nxt     = prev_r;
            out_valid_nxt = 1'b1;
            out_unit_nxt  = grant_of(cur_r);
            out_fail_nxt  = 1'b0;
          end else if (upper_bad) begin
            out_valid_nxt = 1'b1;
            out_unit_nxt  = '0;
            out_fail_nxt  = 1'b1;
          end else begin
            // Split: shrink the free block, hand out its upper end.
            sz_we     = 1'b1;
            sz_waddr  = cur_r;
            sz_wdata  = SW'(CW'(sz_rdata) - CW'(units_r));
            upper_nxt = IW'(upper_w);
            rover_nxt = prev_r;
          end
        end else if (at_rover) begin
          if (grow_bad) begin
            out_valid_nxt = 1'b1;
            out_unit_nxt  = '0;
            out_fail_nxt  = 1'b1;
          end else begin
            // Grow the break and free the new block into the list.
            bp_nxt    = brk_r;
            brk_nxt   = IW'(grow_w);
            sz_we     = 1'b1;
            sz_waddr  = brk_r;
            sz_wdata  = SW'(units_r);
            astep_nxt = astep_r + CNTW'(1);
          end
        end else begin
          prev_nxt  = cur_r;
          cur_nxt   = nx_rdata;
          nx_raddr  = nx_rdata;
          sz_raddr  = nx_rdata;
          astep_nxt = astep_r + CNTW'(1);
        end
      end
      ST_A_SPLIT: begin
        sz_we         = 1'b1;
        sz_waddr      = upper_r;
        sz_wdata      = SW'(units_r);
        out_valid_nxt = 1'b1;
        out_unit_nxt  = grant_of(upper_r);
        out_fail_nxt  = 1'b0;
      end
      ST_F_START: begin
        cur_nxt   = rover_r;
        nx_raddr  = rover_r;
        fstep_nxt = '0;
      end
      ST_F_CHK: begin
        if (fstep_over) begin
          if (!is_alloc_r) begin
            out_valid_nxt = 1'b1;
            out_unit_nxt  = '0;
            out_fail_nxt  = 1'b0;
          end
        end else if (ins_found) begin
          q_nxt    = nx_rdata;
          sz_raddr = bp_r;
          nx_raddr = nx_rdata;
        end else begin
          cur_nxt   = nx_rdata;
          nx_raddr  = nx_rdata;
          fstep_nxt = fstep_r + CNTW'(1);
        end
      end
      ST_F_RD: begin
        sb_nxt   = sz_rdata;
        nq_nxt   = nx_rdata;
        sz_raddr = q_r;
      end
      ST_F_LNK: begin
        // Merge with the upper neighbour when it starts right after the block.
        nx_we    = 1'b1;
        nx_waddr = bp_r;
        sz_we    = 1'b1;
        sz_waddr = bp_r;
        if (hi_adj) begin
          sb_nxt   = SW'(CW'(sb_r) + CW'(sz_rdata));
          sz_wdata = SW'(CW'(sb_r) + CW'(sz_rdata));
          nb_nxt   = nq_r;
          nx_wdata = nq_r;
        end else begin
          sz_wdata = sb_r;
          nb_nxt   = q_r;
          nx_wdata = q_r;
        end
      end
      ST_F_RDP: begin
        sz_raddr = cur_r;
      end
      ST_F_LOW: begin
        // Merge into the lower neighbour when it ends right at the block.
        nx_we    = 1'b1;
        nx_waddr = cur_r;
        if (lo_adj) begin
          sz_we    = 1'b1;
          sz_waddr = cur_r;
          sz_wdata = SW'(CW'(sz_rdata) + CW'(sb_r));
          nx_wdata = nb_r;
        end else begin
          nx_wdata = bp_r;
        end
        rover_nxt = cur_r;
        if (!is_alloc_r) begin
          out_valid_nxt = 1'b1;
          out_unit_nxt  = '0;
          out_fail_nxt  = 1'b0;
        end
      end
      ST_RESP: begin
        if (!out_stall) begin
          out_valid_nxt = 1'b0;
        end
      end
      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rover_r     <= SENT;
      brk_r       <= '0;
      started_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rover_r     <= rover_nxt;
      brk_r       <= brk_nxt;
      started_r   <= started_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    is_alloc_r <= is_alloc_nxt;
    skip_r     <= skip_nxt;
    units_r    <= units_nxt;
    bp_r       <= bp_nxt;
    prev_r     <= prev_nxt;
    cur_r      <= cur_nxt;
    q_r        <= q_nxt;
    nq_r       <= nq_nxt;
    nb_r       <= nb_nxt;
    upper_r    <= upper_nxt;
    sb_r       <= sb_nxt;
    astep_r    <= astep_nxt;
    fstep_r    <= fstep_nxt;
    out_unit_r <= out_unit_nxt;
    out_fail_r <= out_fail_nxt;
  end

  // One request is worked on at a time.
  assign in_stall         = state_r != ST_IDLE;
  assign out_valid        = out_valid_r;
  assign out_granted_unit = out_unit_r;
  assign out_failed       = out_fail_r;

  // A result is only presented while the sequencer waits for it to be taken.
  a_valid_in_resp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> state_r == ST_RESP)
    else $error("result valid outside the response state");

  // A failed request never carries a granted unit.
  a_fail_no_grant: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_fail_r) |-> out_unit_r == '0)
    else $error("failed request with nonzero grant");

  // The break always stays strictly below the heap end.
  a_brk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CW'(brk_r) < CW'(HEAP_UNITS))
    else $error("break reached the heap end");

  // An accepted request starts with list setup in the next cycle.
  a_accept_init: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> state_r == ST_INIT)
    else $error("accepted request did not start");

endmodule
`default_nettype wire
